FILE: hdl/mbd_pkg.sv
// Shared constants and controller/datapath interface types for the Moran birth-death step block.
package mbd_pkg;

   localparam int NODES_DEFAULT = 64;

   localparam int FIT_W       = 15;
   localparam int EPS_W       = 14;
   localparam int DRAW_W      = 16;
   localparam int MNODE_W     = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int STEP_W      = 32;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [FIT_W-1:0]  FIT_ONE  = 15'd16384;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;
   localparam logic              MODE_START = 1'b0;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic load;       // capture request fields, rewind scan
      logic clr_wr;     // clear sweep write, advance index
      logic mul;        // form fitness products and death product
      logic sum;        // total fitness, death rank
      logic tgt;        // roulette target
      logic scan_rd;    // read node type at scan index
      logic scan_chk;   // accumulate fitness, test roulette
      logic death_rd;   // read node type at death node
      logic death_upd;  // copy type, update counts, redraw fitness
      logic start_fin;  // finish a start: counts and fitness
   } mbd_cmd_type;

   // Status back to the sequencer
   typedef struct packed {
      logic absorbed;
      logic idx_last;
      logic hit;
   } mbd_stat_type;

endpackage

FILE: hdl/mbd_ctrl.sv
// Sequencer for the Moran birth-death step block.
module mbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_start,
   input  logic                 out_free,
   input  mbd_pkg::mbd_stat_type stat,
   output logic                 in_ready,
   output logic                 out_load,
   output mbd_pkg::mbd_cmd_type cmd
);
   import mbd_pkg::*;

   typedef enum logic [3:0] {
      IDLE, CLEAR, MUL, SUM, TGT, BRD, BCHK, DRD, DCHK, DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               if (in_start)           state_in = CLEAR;
               else if (stat.absorbed) state_in = DONE;
               else                    state_in = MUL;
            end
         end
         CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.idx_last) begin
               cmd.start_fin = 1'b1;
               state_in      = DONE;
            end
         end
         MUL: begin
            cmd.mul  = 1'b1;
            state_in = SUM;
         end
         SUM: begin
            cmd.sum  = 1'b1;
            state_in = TGT;
         end
         TGT: begin
            cmd.tgt  = 1'b1;
            state_in = BRD;
         end
         BRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = BCHK;
         end
         BCHK: begin
            cmd.scan_chk = 1'b1;
            if (stat.hit || stat.idx_last) state_in = DRD;
            else                           state_in = BRD;
         end
         DRD: begin
            cmd.death_rd = 1'b1;
            state_in     = DCHK;
         end
         DCHK: begin
            cmd.death_upd = 1'b1;
            state_in      = DONE;
         end
         DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: hdl/mbd_dpath.sv
// Datapath for the Moran birth-death step block: node type memory, fitness and counters.
module mbd_dpath #(
   parameter int NODES = mbd_pkg::NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mbd_pkg::mbd_cmd_type              cmd,
   output mbd_pkg::mbd_stat_type             stat,
   input  logic                              csr_wr,
   input  logic [mbd_pkg::EPS_W-1:0]         csr_data,
   input  logic [mbd_pkg::MNODE_W-1:0]       in_mnode,
   input  logic [mbd_pkg::DRAW_W-1:0]        in_bdraw,
   input  logic [mbd_pkg::DRAW_W-1:0]        in_ddraw,
   input  logic                              in_rsign,
   input  logic                              in_msign,
   output logic [mbd_pkg::COUNT_OUT_W-1:0]   mutant_count,
   output logic [mbd_pkg::STEP_W-1:0]        step_count,
   output logic                              absorbed,
   output logic                              fixated
);
   import mbd_pkg::*;

   localparam int NW  = $clog2(NODES);
   localparam int CW  = $clog2(NODES + 1);
   localparam int TW  = FIT_W + CW;
   localparam int TGW = TW + DRAW_W;
   localparam int DPW = DRAW_W + NW;
   localparam int XW  = ((NW > MNODE_W) ? NW : MNODE_W) + 1;

   localparam logic [NW-1:0] LAST_IDX   = NW'(NODES - 1);
   localparam logic [CW-1:0] NODES_CNT  = CW'(NODES);
   localparam logic [CW-1:0] ONE_CNT    = CW'(1);

   function automatic logic [FIT_W-1:0] draw_fit(input logic sgn,
                                                  input logic [EPS_W-1:0] eps);
      return sgn ? (FIT_ONE + FIT_W'(eps)) : (FIT_ONE - FIT_W'(eps));
   endfunction

   logic                  node_mem [NODES];
   logic                  rd_ff;

   logic [EPS_W-1:0]      epsilon_ff;
   logic [FIT_W-1:0]      rfit_ff, mfit_ff;
   logic [CW-1:0]         mutants_ff;
   logic [STEP_W-1:0]     steps_ff;

   logic [NW-1:0]         mnode_ff;
   logic [DRAW_W-1:0]     bdraw_ff, ddraw_ff;
   logic                  rsign_ff, msign_ff;

   logic [NW-1:0]         idx_ff;
   logic [TW-1:0]         cum_ff;
   logic [TW-1:0]         prod_r_ff, prod_m_ff, total_ff;
   logic [DPW-1:0]        dprod_ff;
   logic [TGW-1:0]        target_ff;
   logic [NW-1:0]         death0_ff, death_ff, birth_ff;
   logic                  btype_ff;

   logic [NW-1:0]         mnode_sat;
   logic [CW-1:0]         nres;
   logic [DPW:0]          cvec;
   logic [NW:0]           c_raw;
   logic [NW-1:0]         c_clamp;
   logic [FIT_W-1:0]      fit_sel;
   logic [TW-1:0]         cum_nx;
   logic                  hit;
   logic [NW-1:0]         death_w;
   logic                  differ;
   logic                  wr_en, wr_data;
   logic [NW-1:0]         wr_addr, rd_addr;

   // Saturate an out-of-range initial mutant to the last node
   assign mnode_sat = (XW'(in_mnode) >= XW'(NODES)) ? LAST_IDX : NW'(in_mnode);

   assign nres = NODES_CNT - mutants_ff;

   // Death rank: ceil(draw * (NODES-1) / 2^16), held to 1..NODES-1
   assign cvec  = (DPW+1)'(dprod_ff) + (DPW+1)'({DRAW_W{1'b1}});
   assign c_raw = cvec[DPW:DRAW_W];
   always_comb begin
      if (c_raw == '0)                     c_clamp = NW'(1);
      else if (c_raw > (NW+1)'(LAST_IDX))  c_clamp = LAST_IDX;
      else                                 c_clamp = c_raw[NW-1:0];
   end

   assign fit_sel = rd_ff ? mfit_ff : rfit_ff;
   assign cum_nx  = cum_ff + TW'(fit_sel);
   assign hit     = target_ff <= {cum_nx, {DRAW_W{1'b0}}};

   // Skip over the birth node
   assign death_w = (death0_ff >= birth_ff) ? (death0_ff + NW'(1)) : death0_ff;
   assign differ  = rd_ff != btype_ff;

   assign wr_en   = cmd.clr_wr || (cmd.death_upd && differ);
   assign wr_addr = cmd.clr_wr ? idx_ff : death_ff;
   assign wr_data = cmd.clr_wr ? (idx_ff == mnode_ff) : btype_ff;
   assign rd_addr = cmd.death_rd ? death_w : idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) node_mem[wr_addr] <= wr_data;
      rd_ff <= node_mem[rd_addr];
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= '0;
         rfit_ff    <= FIT_ONE;
         mfit_ff    <= FIT_ONE;
         mutants_ff <= '0;
         steps_ff   <= '0;
      end else begin
         if (csr_wr) epsilon_ff <= csr_data;
         if (cmd.start_fin) begin
            mutants_ff <= ONE_CNT;
            steps_ff   <= '0;
            rfit_ff    <= draw_fit(rsign_ff, epsilon_ff);
            mfit_ff    <= draw_fit(msign_ff, epsilon_ff);
         end
         if (cmd.death_upd) begin
            if (differ) begin
               if (btype_ff) mutants_ff <= mutants_ff + ONE_CNT;
               else          mutants_ff <= mutants_ff - ONE_CNT;
            end
            if (steps_ff != STEP_MAX) steps_ff <= steps_ff + STEP_W'(1);
            rfit_ff <= draw_fit(rsign_ff, epsilon_ff);
            mfit_ff <= draw_fit(msign_ff, epsilon_ff);
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mnode_ff <= mnode_sat;
         bdraw_ff <= in_bdraw;
         ddraw_ff <= in_ddraw;
         rsign_ff <= in_rsign;
         msign_ff <= in_msign;
         idx_ff   <= '0;
         cum_ff   <= '0;
      end
      if (cmd.clr_wr) idx_ff <= idx_ff + NW'(1);
      if (cmd.mul) begin
         prod_r_ff <= TW'(rfit_ff) * TW'(nres);
         prod_m_ff <= TW'(mfit_ff) * TW'(mutants_ff);
         dprod_ff  <= DPW'(ddraw_ff) * DPW'(LAST_IDX);
      end
      if (cmd.sum) begin
         total_ff  <= prod_r_ff + prod_m_ff;
         death0_ff <= c_clamp - NW'(1);
      end
      if (cmd.tgt) target_ff <= TGW'(bdraw_ff) * TGW'(total_ff);
      if (cmd.scan_chk) begin
         cum_ff   <= cum_nx;
         idx_ff   <= idx_ff + NW'(1);
         birth_ff <= idx_ff;
         btype_ff <= rd_ff;
      end
      if (cmd.death_rd) death_ff <= death_w;
   end

   assign stat.absorbed = (mutants_ff == '0) || (mutants_ff == NODES_CNT);
   assign stat.idx_last = idx_ff == LAST_IDX;
   assign stat.hit      = hit;

   assign mutant_count = COUNT_OUT_W'(mutants_ff);
   assign step_count   = steps_ff;
   assign absorbed     = stat.absorbed;
   assign fixated      = mutants_ff == NODES_CNT;

endmodule

FILE: hdl/moran_birth_death_step_top.sv
// Top level of the Moran birth-death step block: channels, sequencer, datapath, result register.
//
// Usage:
//   req_* carries one item per transfer: tuser selects start (0) or step (1).
//   A start clears every node to resident, seeds one mutant, zeroes the step
//   count and draws both fitnesses. A step runs one birth-death update.
//   rsp_* returns exactly one result per request, in request order.
//   csr_* writes epsilon; write it only while the block is idle.
// Processing (one item at a time):
//   start: length set by the clear sweep over the node memory.
//   step : length grows with b, the birth node index; the birth roulette
//          reads each node from the node memory with registered read data,
//          in a read state followed by a check state.
//   step while absorbed: no update; the counts are reported unchanged.
// A finished result waits in the output register; the next request is
// taken meanwhile, and its result holds in the datapath until the output
// register frees. While rsp_tready is low, rsp_tdata holds.
// Reset clears the counts, epsilon and both fitnesses to one; node memory
// contents are rewritten by the next start before they are used.
module moran_birth_death_step_top #(
   parameter int NODES = mbd_pkg::NODES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [5:0] mutant_node, [21:6] birth_draw, [37:22] death_draw,
   // [38] resident_sign, [39] mutant_sign
   input  logic [mbd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] mode
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [6:0] mutant_count, [38:7] step_count, [39] absorbed, [40] fixated,
   // [47:41] zero
   output logic [mbd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbd_pkg::EPS_W-1:0]        csr_data
);
   import mbd_pkg::*;

   mbd_cmd_type  cmd;
   mbd_stat_type stat;

   logic                   out_free, out_load;
   logic [COUNT_OUT_W-1:0] mutant_count;
   logic [STEP_W-1:0]      step_count;
   logic                   absorbed, fixated;

   logic                   rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff;

   // Output register is free when empty or being drained this cycle
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   // Epsilon register takes a write in any cycle
   assign csr_ready = 1'b1;

   mbd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_start (req_tuser == MODE_START),
      .out_free (out_free),
      .stat     (stat),
      .in_ready (req_tready),
      .out_load (out_load),
      .cmd      (cmd)
   );

   mbd_dpath #(
      .NODES (NODES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_wr       (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .in_mnode     (req_tdata[5:0]),
      .in_bdraw     (req_tdata[21:6]),
      .in_ddraw     (req_tdata[37:22]),
      .in_rsign     (req_tdata[38]),
      .in_msign     (req_tdata[39]),
      .mutant_count (mutant_count),
      .step_count   (step_count),
      .absorbed     (absorbed),
      .fixated      (fixated)
   );

   // Result register: load on finish, drop valid after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= {7'd0, fixated, absorbed, step_count, mutant_count};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: tb/sv/moran_birth_death_step_top_tb.sv
// Self-checking testbench for the Moran birth-death step block: directed table, then random trials.
module moran_birth_death_step_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbd_pkg::*;

   localparam int NODES        = NODES_DEFAULT;
   localparam int RANDOM_ITEMS = 1450;
   localparam int QUIET_ITEMS  = 150;      // last random items run with no idling
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * NODES + 16;

   localparam logic MODE_STEP = !MODE_START;
   localparam logic KNOWN     = 1'b1;      // row carries its own expected result
   localparam logic PREDICT   = 1'b0;      // row is checked against the predictor

   localparam logic [EPS_W-1:0] EPS_MAX = '1;

   // One request, laid out as req_tdata: last field in the lowest bits.
   typedef struct packed {
      logic                 mutant_sign;
      logic                 resident_sign;
      logic [DRAW_W-1:0]    death_draw;
      logic [DRAW_W-1:0]    birth_draw;
      logic [MNODE_W-1:0]   mutant_node;
   } moran_req_type;

   // One report, laid out as rsp_tdata.
   typedef struct packed {
      logic [RSP_DATA_W-42:0]  pad;
      logic                    fixated;
      logic                    absorbed;
      logic [STEP_W-1:0]       step_count;
      logic [COUNT_OUT_W-1:0]  mutant_count;
   } trial_report_type;

   typedef enum logic {ROW_ITEM, ROW_EPS} row_kind_type;
   typedef enum int {FAVOR_MUTANT, FAVOR_RESIDENT, FAVOR_NONE} trial_bias_type;

   typedef struct packed {
      row_kind_type           kind;
      logic                   mode;
      logic [MNODE_W-1:0]     node;
      logic [DRAW_W-1:0]      bdraw;
      logic [DRAW_W-1:0]      ddraw;
      logic                   rsign;
      logic                   msign;
      logic [EPS_W-1:0]       eps;
      logic                   known;
      logic [COUNT_OUT_W-1:0] k_count;
      logic [STEP_W-1:0]      k_steps;
      logic                   k_abs;
      logic                   k_fix;
   } directed_row_type;

   // Directed table. Columns: kind, mode, node, birth draw, death draw, resident sign,
   // mutant sign, epsilon, known, then count, steps, absorbed, fixated when known.
   localparam directed_row_type DIRECTED_ROWS [0:19] = '{
      // step before any start: absorbed at count zero, nothing moves
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 14'd0,
        KNOWN, 7'd0, 32'd0, 1'b1, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 14'd0,
        KNOWN, 7'd0, 32'd0, 1'b1, 1'b0},
      // start at the lowest node, draws at the low extreme
      '{ROW_ITEM, MODE_START, 6'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 14'd0,
        KNOWN, 7'd1, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      // start at the highest node
      '{ROW_ITEM, MODE_START, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 14'd0,
        KNOWN, 7'd1, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd63, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd21, 16'h8000, 16'h8000, 1'b1, 1'b1, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_EPS,  MODE_STEP,  6'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, EPS_MAX,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      // weak mutant on node 5; birth at node 0, death rank lands on node 5: extinction
      '{ROW_ITEM, MODE_START, 6'd5,  16'h0000, 16'h0000, 1'b1, 1'b0, 14'd0,
        KNOWN, 7'd1, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'h0000, 16'd4200, 1'b1, 1'b0, 14'd0,
        KNOWN, 7'd0, 32'd1, 1'b1, 1'b0},
      // step while absorbed reports the frozen state
      '{ROW_ITEM, MODE_STEP,  6'd42, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 14'd0,
        KNOWN, 7'd0, 32'd1, 1'b1, 1'b0},
      // strong mutant in the middle
      '{ROW_ITEM, MODE_START, 6'd31, 16'h1234, 16'h4321, 1'b0, 1'b1, 14'd0,
        KNOWN, 7'd1, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'h0001, 16'hFFFF, 1'b0, 1'b1, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'h7FFF, 16'h0001, 1'b0, 1'b1, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'hFFFF, 16'h8000, 1'b1, 1'b0, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_EPS,  MODE_STEP,  6'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, 14'd1,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_START, 6'd42, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 14'd0,
        KNOWN, 7'd1, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'hAAAA, 16'h5555, 1'b1, 1'b0, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0},
      '{ROW_ITEM, MODE_STEP,  6'd0,  16'h5555, 16'hAAAA, 1'b0, 1'b1, 14'd0,
        PREDICT, 7'd0, 32'd0, 1'b0, 1'b0}
   };

   // ---------------------------------------------------------------- DUT signals
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = MODE_START;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [EPS_W-1:0]       csr_data   = '0;

   moran_birth_death_step_top #(.NODES(NODES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- population model
   // Shadow copy of the block's state; advanced once per accepted request.
   logic              node_is_mutant [NODES] = '{default: 1'b0};
   logic [FIT_W-1:0]  resident_fit = FIT_ONE;
   logic [FIT_W-1:0]  mutant_fit   = FIT_ONE;
   logic [EPS_W-1:0]  noise_eps    = '0;
   int                mutant_total = 0;
   logic [STEP_W-1:0] trial_steps  = '0;

   trial_report_type expected_reports [$];

   int  mismatches     = 0;
   int  cycle_count    = 0;
   int  random_sent    = 0;
   int  src_gap_pct    = 0;
   int  sink_stall_pct = 0;
   int  sink_hold      = 0;
   bit  quiet_tail     = 1'b0;

   function automatic logic [FIT_W-1:0] noisy_fitness(input logic plus);
      return plus ? FIT_W'(FIT_ONE + noise_eps) : FIT_W'(FIT_ONE - noise_eps);
   endfunction

   // Apply one request to the model and return the report it should produce.
   function automatic trial_report_type moran_update(input logic mode,
                                                     input moran_req_type it);
      logic [63:0]      total;
      logic [63:0]      target;
      logic [63:0]      cum;
      logic [63:0]      rank;
      int               n;
      int               birth;
      int               death;
      bit               found;
      trial_report_type r;
      if (mode == MODE_START) begin
         for (n = 0; n < NODES; n++)
            node_is_mutant[n] = 1'b0;
         // an index past the last node saturates to the last node
         node_is_mutant[(int'(it.mutant_node) >= NODES) ? NODES - 1 : int'(it.mutant_node)]
            = 1'b1;
         mutant_total = 1;
         trial_steps  = '0;
         resident_fit = noisy_fitness(it.resident_sign);
         mutant_fit   = noisy_fitness(it.mutant_sign);
      end else if (mutant_total != 0 && mutant_total != NODES) begin
         total  = 64'(resident_fit) * 64'(NODES - mutant_total)
                + 64'(mutant_fit) * 64'(mutant_total);
         target = 64'(it.birth_draw) * total;
         // roulette: first node whose running fitness sum covers the target
         cum   = '0;
         birth = NODES - 1;
         found = 1'b0;
         for (n = 0; n < NODES; n++) begin
            cum = cum + 64'(node_is_mutant[n] ? mutant_fit : resident_fit);
            if (!found && target <= (cum << 16)) begin
               birth = n;
               found = 1'b1;
            end
         end
         // death: rank among the other nodes, rounded up, kept in 1..NODES-1
         rank = (64'(it.death_draw) * 64'(NODES - 1) + 64'd65535) >> 16;
         if (rank == 0)
            rank = 1;
         if (rank > 64'(NODES - 1))
            rank = 64'(NODES - 1);
         death = int'(rank) - 1;
         if (death >= birth)
            death++;
         if (node_is_mutant[birth] != node_is_mutant[death]) begin
            mutant_total = node_is_mutant[birth] ? mutant_total + 1 : mutant_total - 1;
            node_is_mutant[death] = node_is_mutant[birth];
         end
         if (trial_steps != STEP_MAX)
            trial_steps = trial_steps + 1;
         resident_fit = noisy_fitness(it.resident_sign);
         mutant_fit   = noisy_fitness(it.mutant_sign);
      end
      r.pad          = '0;
      r.mutant_count = COUNT_OUT_W'(mutant_total);
      r.step_count   = trial_steps;
      r.absorbed     = (mutant_total == 0 || mutant_total == NODES);
      r.fixated      = (mutant_total == NODES);
      return r;
   endfunction

   function automatic int idle_rate();
      case ($urandom_range(2, 0))
         0: return 0;
         1: return 8;
         default: return 35;
      endcase
   endfunction

   // ---------------------------------------------------------------- request side
   // Present one request, hold it until the transfer, then record its report.
   task automatic send_item(input logic mode, input moran_req_type it,
                            input logic known, input trial_report_type known_report);
      trial_report_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= it;
      do @(posedge clock); while (!req_tready);
      predicted = moran_update(mode, it);
      expected_reports.push_back(known ? known_report : predicted);
   endtask

   // Drop valid for a random burst, unless idling is off.
   task automatic source_gap();
      if (!quiet_tail && $urandom_range(99, 0) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
   endtask

   // Write epsilon once the block is idle: no request pending, every report back.
   task automatic write_epsilon(input logic [EPS_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      noise_eps = value;
   endtask

   // Random trials: mostly a start followed by a run of steps up to absorption,
   // with biased fitness signs so runs reach fixation as well as extinction.
   task automatic run_trials(input logic [EPS_W-1:0] eps, input int quota);
      int             done;
      int             trial_len;
      int             trial_n;
      int             absorbed_steps;
      int             absorbed_limit;
      int             pick;
      bit             absorbed_now;
      logic           mode;
      trial_bias_type bias;
      moran_req_type  it;
      done = 0;
      write_epsilon(eps);
      while (done < quota) begin
         pick = $urandom_range(9, 0);
         bias = (pick < 6) ? FAVOR_MUTANT : (pick < 8) ? FAVOR_RESIDENT : FAVOR_NONE;
         trial_len      = $urandom_range(400, 8);
         trial_n        = 0;
         absorbed_steps = 0;
         absorbed_limit = $urandom_range(2, 0);
         mode           = MODE_START;
         while (done < quota && trial_n <= trial_len && absorbed_steps <= absorbed_limit) begin
            it.mutant_node = MNODE_W'($urandom);
            it.birth_draw  = DRAW_W'($urandom);
            it.death_draw  = DRAW_W'($urandom);
            case (bias)
               FAVOR_MUTANT:   begin
                  it.resident_sign = 1'b0;
                  it.mutant_sign   = 1'b1;
               end
               FAVOR_RESIDENT: begin
                  it.resident_sign = 1'b1;
                  it.mutant_sign   = 1'b0;
               end
               default:        begin
                  it.resident_sign = 1'($urandom);
                  it.mutant_sign   = 1'($urandom);
               end
            endcase
            // occasional sign noise inside a biased trial
            if ($urandom_range(19, 0) == 0) begin
               it.resident_sign = 1'($urandom);
               it.mutant_sign   = 1'($urandom);
            end
            absorbed_now = (mode == MODE_STEP) && (mutant_total == 0 || mutant_total == NODES);
            if (random_sent % 64 == 0) begin
               src_gap_pct    = idle_rate();
               sink_stall_pct = idle_rate();
            end
            if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS)
               quiet_tail = 1'b1;
            source_gap();
            send_item(mode, it, PREDICT, '0);
            if (absorbed_now)
               absorbed_steps++;
            else begin
               done++;
               random_sent++;
            end
            trial_n++;
            // rarely break the trial with an early restart
            mode = ($urandom_range(40, 0) == 0) ? MODE_START : MODE_STEP;
         end
      end
   endtask

   // ---------------------------------------------------------------- result side
   // Stall the result channel in random bursts; none in the quiet tail.
   always @(posedge clock) begin
      if (sink_hold != 0) begin
         sink_hold  <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(99, 0) < sink_stall_pct) begin
         sink_hold  <= $urandom_range(12, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each report transfer with the oldest expectation.
   always @(posedge clock) begin
      trial_report_type got;
      trial_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_reports.size() == 0) begin
            $error("report with nothing expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (got.mutant_count !== want.mutant_count) begin
               $error("mutant_count: expected %0d, actual %0d",
                      want.mutant_count, got.mutant_count);
               mismatches++;
            end
            if (got.step_count !== want.step_count) begin
               $error("step_count: expected %0d, actual %0d", want.step_count, got.step_count);
               mismatches++;
            end
            if (got.absorbed !== want.absorbed) begin
               $error("absorbed: expected %0d, actual %0d", want.absorbed, got.absorbed);
               mismatches++;
            end
            if (got.fixated !== want.fixated) begin
               $error("fixated: expected %0d, actual %0d", want.fixated, got.fixated);
               mismatches++;
            end
         end
      end
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("moran_birth_death_step_top verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      directed_row_type row;
      moran_req_type    it;
      trial_report_type known_report;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table, epsilon still at its reset value until the first write row.
      src_gap_pct    = 20;
      sink_stall_pct = 20;
      foreach (DIRECTED_ROWS[r]) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_EPS)
            write_epsilon(row.eps);
         else begin
            it.mutant_node             = row.node;
            it.birth_draw              = row.bdraw;
            it.death_draw              = row.ddraw;
            it.resident_sign           = row.rsign;
            it.mutant_sign             = row.msign;
            known_report.pad           = '0;
            known_report.mutant_count  = row.k_count;
            known_report.step_count    = row.k_steps;
            known_report.absorbed      = row.k_abs;
            known_report.fixated       = row.k_fix;
            source_gap();
            send_item(row.mode, it, row.known, known_report);
         end
      end

      // Random trials over several epsilon settings, extremes included.
      run_trials(EPS_MAX, 560);
      run_trials('0, 250);
      run_trials(EPS_W'($urandom_range(16382, 1)), 300);
      run_trials(EPS_MAX, RANDOM_ITEMS - 1110);

      // Drain: every report back, then let any trailing activity settle.
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("moran_birth_death_step_top verification clean");
      else
         $display("moran_birth_death_step_top verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/mbd_pkg.sv
hdl/mbd_ctrl.sv
hdl/mbd_dpath.sv
hdl/moran_birth_death_step_top.sv
tb/sv/moran_birth_death_step_top_tb.sv
